[hdl/hbto_pkg.sv]
// Shared types, constants and tables for the harmonic bass tone oscillator.
package hbto_pkg;

    localparam int PHASE_BITS_DEFAULT = 32;
    localparam int SINE_ENTRIES_DEFAULT = 1024;

    localparam int NOTE_BITS = 7;
    localparam int NOTE_COUNT = 128;
    localparam int GAIN_BITS = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int FREQ_BITS = 30;
    localparam int STEP_BITS = 28;
    localparam int WEIGHT_BITS = 15;
    localparam int HARM_BITS = 3;
    localparam int MAX_HARMONICS = 5;
    localparam int MODE_COUNT = 4;
    localparam int POLY_BITS = 31;
    localparam int MUL_BITS = 32;

    // Item operation codes.
    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_NOTE_OFF = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 28;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ARTICULATION = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP   = 2'd1;

    localparam logic [1:0] ARTICULATION_RESET = 2'd1;
    localparam logic [STEP_BITS-1:0] PHASE_STEP_RESET = 28'd22906492;

    // Harmonic weights per articulation, mix gain folded in, unsigned Q15.
    localparam logic [WEIGHT_BITS-1:0] MODE_WEIGHTS [MODE_COUNT][MAX_HARMONICS] = '{
        '{15'd19661, 15'd5898, 15'd2949, 15'd0, 15'd0},
        '{15'd22938, 15'd3441, 15'd0, 15'd0, 15'd0},
        '{15'd16384, 15'd6554, 15'd4096, 15'd2458, 15'd1638},
        '{15'd13107, 15'd0, 15'd0, 15'd0, 15'd0}
    };

    localparam logic [HARM_BITS-1:0] MODE_HARMONICS [MODE_COUNT] = '{
        3'd3, 3'd2, 3'd5, 3'd1
    };

    // Odd Taylor series of sin(pi/2 x) in Q30, evaluated by Horner steps in x^2.
    localparam logic [POLY_BITS-1:0] HORNER_SEED = 31'd172272;
    localparam logic [POLY_BITS-1:0] HORNER_COEF [4] = '{
        31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
    };

    // Top octave (notes 116 to 127) in Hz, Q16.
    localparam logic [FREQ_BITS-1:0] TOP_OCTAVE_Q16 [12] = '{
        30'd435478539, 30'd461373440, 30'd488808132, 30'd517874176,
        30'd548668578, 30'd581294109, 30'd615859655, 30'd652480576,
        30'd691279090, 30'd732384684, 30'd775934544, 30'd822074013
    };

    typedef logic [FREQ_BITS-1:0] freq_rom_t [NOTE_COUNT];

    // Each lower octave halves the frequency, rounding half up.
    function automatic freq_rom_t build_freq_rom();
        freq_rom_t rom;
        int d;
        int s;
        logic [63:0] f;
        for (int n = 0; n < NOTE_COUNT; n++)
        begin
            d = 127 - n;
            s = d / 12;
            f = 64'(TOP_OCTAVE_Q16[11 - (d % 12)]);
            if (s > 0)
            begin
                f = (f + (64'd1 << (s - 1))) >> s;
            end
            rom[n] = f[FREQ_BITS-1:0];
        end
        return rom;
    endfunction

    localparam freq_rom_t FREQ_ROM = build_freq_rom();

    typedef enum logic [3:0] {
        DP_NOP,
        DP_NOTE_INC,
        DP_HARM,
        DP_SQUARE,
        DP_HORNER,
        DP_YMUL,
        DP_YRND,
        DP_WMUL,
        DP_EVMUL,
        DP_BIGMUL,
        DP_ROUND,
        DP_ZERO
    } hbto_dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NOTE,
        ST_EV,
        ST_HARM,
        ST_SQ,
        ST_HORN,
        ST_YMUL,
        ST_YRND,
        ST_WMUL,
        ST_BIG,
        ST_ROUND,
        ST_OUT
    } hbto_state_t;

    typedef struct packed {
        logic                 note_accept;
        logic                 tick_accept;
        logic                 note_off;
        logic                 out_load;
        hbto_dp_op_t          dp_op;
        logic [HARM_BITS-1:0] harm;
        logic [1:0]           horner_k;
    } hbto_cmd_t;

    typedef struct packed {
        logic                 active;
        logic [HARM_BITS-1:0] harmonics;
    } hbto_status_t;

endpackage

[hdl/hbto_datapath.sv]
// Oscillator datapath: voice state, configuration registers and the shared multiplier.
module hbto_datapath #(
    parameter int PHASE_BITS = hbto_pkg::PHASE_BITS_DEFAULT,
    parameter int SINE_TABLE_ENTRIES = hbto_pkg::SINE_ENTRIES_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  hbto_pkg::hbto_cmd_t                   cmd,
    output hbto_pkg::hbto_status_t                status,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [hbto_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [hbto_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic [hbto_pkg::NOTE_BITS-1:0]        note,
    input  logic [hbto_pkg::GAIN_BITS-1:0]        velocity_gain,
    input  logic [hbto_pkg::GAIN_BITS-1:0]        envelope_gain,
    output logic signed [hbto_pkg::SAMPLE_BITS-1:0] sample
);
    import hbto_pkg::*;

    localparam int IDX_BITS = $clog2(SINE_TABLE_ENTRIES);
    localparam int QB = IDX_BITS - 2;
    localparam int INC_SHIFT = 56 - PHASE_BITS;
    localparam logic [QB:0] QUARTER = (QB+1)'(1) << QB;

    logic [1:0]            art_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [PHASE_BITS-1:0] inc_reg, inc_next;
    logic [GAIN_BITS-1:0]  vel_reg, vel_next;
    logic                  active_reg, active_next;

    logic [NOTE_BITS-1:0]  note_reg;
    logic [GAIN_BITS-1:0]  env_reg;
    logic [PHASE_BITS-1:0] hp_reg, hp_next;
    logic [POLY_BITS-1:0]  x_reg, x_next;
    logic                  neg_reg, neg_next;
    logic [POLY_BITS-1:0]  x2_reg, x2_next;
    logic [POLY_BITS-1:0]  p_reg, p_next;
    logic [31:0]           y_reg, y_next;
    logic [WEIGHT_BITS-1:0] s_reg, s_next;
    logic signed [31:0]    acc_reg, acc_next;
    logic [31:0]           ev_reg, ev_next;
    logic [61:0]           big_reg, big_next;
    logic signed [SAMPLE_BITS-1:0] res_reg, res_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    logic [MUL_BITS-1:0]   mul_a, mul_b;
    logic [63:0]           prod;

    logic [PHASE_BITS-1:0] hp_sum;
    logic [IDX_BITS-1:0]   idx;
    logic [1:0]            quad;
    logic [QB:0]           r_fold;
    logic [31:0]           horner_diff;
    logic [32:0]           y_sum;
    logic [17:0]           y_q;
    logic signed [31:0]    wterm;
    logic [31:0]           acc_mag;
    logic [62:0]           round_sum;
    logic [17:0]           q;

    assign cfg_ready = 1'b1;
    assign status.active = active_reg;
    assign status.harmonics = MODE_HARMONICS[art_reg];
    assign sample = sample_reg;

    // One multiplier serves every product; the operation picks its operands.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.dp_op)
            DP_NOTE_INC:
            begin
                mul_a = MUL_BITS'(FREQ_ROM[note_reg]);
                mul_b = MUL_BITS'(step_reg);
            end
            DP_SQUARE:
            begin
                mul_a = MUL_BITS'(x_reg);
                mul_b = MUL_BITS'(x_reg);
            end
            DP_HORNER:
            begin
                mul_a = MUL_BITS'(p_reg);
                mul_b = MUL_BITS'(x2_reg);
            end
            DP_YMUL:
            begin
                mul_a = MUL_BITS'(p_reg);
                mul_b = MUL_BITS'(x_reg);
            end
            DP_WMUL:
            begin
                mul_a = MUL_BITS'(MODE_WEIGHTS[art_reg][cmd.harm]);
                mul_b = MUL_BITS'(s_reg);
            end
            DP_EVMUL:
            begin
                mul_a = MUL_BITS'(env_reg);
                mul_b = MUL_BITS'(vel_reg);
            end
            DP_BIGMUL:
            begin
                mul_a = acc_mag;
                mul_b = ev_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    // Harmonic phase is built by repeated addition; its top bits address the sine.
    assign hp_sum = hp_reg + phase_reg;
    assign idx = hp_sum[PHASE_BITS-1 -: IDX_BITS];
    assign quad = idx[IDX_BITS-1 -: 2];
    assign r_fold = quad[0] ? (QUARTER - {1'b0, idx[QB-1:0]}) : {1'b0, idx[QB-1:0]};

    assign horner_diff = {1'b0, HORNER_COEF[cmd.horner_k]} - prod[61:30];
    assign y_sum = {1'b0, y_reg} + 33'd16384;
    assign y_q = y_sum[32:15];
    assign wterm = signed'({2'b00, prod[29:0]});
    assign acc_mag = acc_reg[31] ? 32'(-acc_reg) : 32'(acc_reg);
    assign round_sum = {1'b0, big_reg} + (63'd1 << 44);
    assign q = round_sum[62:45];

    always_comb
    begin
        phase_next = phase_reg;
        inc_next = inc_reg;
        vel_next = vel_reg;
        active_next = active_reg;
        hp_next = hp_reg;
        x_next = x_reg;
        neg_next = neg_reg;
        x2_next = x2_reg;
        p_next = p_reg;
        y_next = y_reg;
        s_next = s_reg;
        acc_next = acc_reg;
        ev_next = ev_reg;
        big_next = big_reg;
        res_next = res_reg;

        if (cmd.note_accept)
        begin
            vel_next = velocity_gain;
            phase_next = '0;
            active_next = 1'b1;
        end
        if (cmd.note_off)
        begin
            active_next = 1'b0;
        end
        if (cmd.tick_accept)
        begin
            hp_next = '0;
            acc_next = '0;
        end

        case (cmd.dp_op)
            DP_NOTE_INC:
            begin
                inc_next = prod[INC_SHIFT +: PHASE_BITS];
            end
            DP_HARM:
            begin
                hp_next = hp_sum;
                x_next = POLY_BITS'(r_fold) << (30 - QB);
                neg_next = quad[1];
            end
            DP_SQUARE:
            begin
                x2_next = prod[60:30];
                p_next = HORNER_SEED;
            end
            DP_HORNER:
            begin
                p_next = horner_diff[POLY_BITS-1:0];
            end
            DP_YMUL:
            begin
                y_next = prod[61:30];
            end
            DP_YRND:
            begin
                s_next = (y_q > 18'd32767) ? 15'h7FFF : y_q[WEIGHT_BITS-1:0];
            end
            DP_WMUL:
            begin
                acc_next = neg_reg ? (acc_reg - wterm) : (acc_reg + wterm);
            end
            DP_EVMUL:
            begin
                ev_next = prod[31:0];
            end
            DP_BIGMUL:
            begin
                big_next = prod[61:0];
            end
            DP_ROUND:
            begin
                if (acc_reg[31])
                begin
                    res_next = (q > 18'd32768) ? 16'sh8000 : signed'(16'(18'd0 - q));
                end
                else
                begin
                    res_next = (q > 18'd32767) ? 16'sh7FFF : signed'(q[15:0]);
                end
                phase_next = phase_reg + inc_reg;
            end
            DP_ZERO:
            begin
                res_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            art_reg <= ARTICULATION_RESET;
            step_reg <= PHASE_STEP_RESET;
            phase_reg <= '0;
            inc_reg <= '0;
            vel_reg <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ARTICULATION: art_reg <= cfg_data[1:0];
                    REG_PHASE_STEP:   step_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            phase_reg <= phase_next;
            inc_reg <= inc_next;
            vel_reg <= vel_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.note_accept)
        begin
            note_reg <= note;
        end
        if (cmd.tick_accept)
        begin
            env_reg <= envelope_gain;
        end
        if (cmd.out_load)
        begin
            sample_reg <= res_reg;
        end
        hp_reg <= hp_next;
        x_reg <= x_next;
        neg_reg <= neg_next;
        x2_reg <= x2_next;
        p_reg <= p_next;
        y_reg <= y_next;
        s_reg <= s_next;
        acc_reg <= acc_next;
        ev_reg <= ev_next;
        big_reg <= big_next;
        res_reg <= res_next;
    end

endmodule

[hdl/hbto_ctrl.sv]
// Oscillator controller: sequences note events, the per-harmonic sine steps and output beats.
module hbto_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic [1:0]             op,
    output logic                   sample_valid,
    input  logic                   sample_stall,
    input  hbto_pkg::hbto_status_t status,
    output hbto_pkg::hbto_cmd_t    cmd
);
    import hbto_pkg::*;

    hbto_state_t state_reg, state_next;
    logic [HARM_BITS-1:0] h_reg, h_next;
    logic [1:0] k_reg, k_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;
    logic more_harm;

    assign slot_free = !out_valid_reg || !sample_stall;
    assign more_harm = ({1'b0, h_reg} + 4'd1) < {1'b0, status.harmonics};
    assign sample_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (op)
                        OP_NOTE_ON: state_next = ST_NOTE;
                        OP_TICK:    state_next = status.active ? ST_EV : ST_OUT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_NOTE:  state_next = ST_IDLE;
            ST_EV:    state_next = ST_HARM;
            ST_HARM:  state_next = ST_SQ;
            ST_SQ:    state_next = ST_HORN;
            ST_HORN:  state_next = (k_reg == 2'd3) ? ST_YMUL : ST_HORN;
            ST_YMUL:  state_next = ST_YRND;
            ST_YRND:  state_next = ST_WMUL;
            ST_WMUL:  state_next = more_harm ? ST_HARM : ST_BIG;
            ST_BIG:   state_next = ST_ROUND;
            ST_ROUND: state_next = ST_OUT;
            ST_OUT:   state_next = slot_free ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.dp_op = DP_NOP;
        cmd.harm = h_reg;
        cmd.horner_k = k_reg;
        item_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (op)
                        OP_NOTE_ON:
                        begin
                            cmd.note_accept = 1'b1;
                        end
                        OP_TICK:
                        begin
                            if (status.active)
                            begin
                                cmd.tick_accept = 1'b1;
                            end
                            else
                            begin
                                cmd.dp_op = DP_ZERO;
                            end
                        end
                        OP_NOTE_OFF:
                        begin
                            cmd.note_off = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_NOTE:  cmd.dp_op = DP_NOTE_INC;
            ST_EV:    cmd.dp_op = DP_EVMUL;
            ST_HARM:  cmd.dp_op = DP_HARM;
            ST_SQ:    cmd.dp_op = DP_SQUARE;
            ST_HORN:  cmd.dp_op = DP_HORNER;
            ST_YMUL:  cmd.dp_op = DP_YMUL;
            ST_YRND:  cmd.dp_op = DP_YRND;
            ST_WMUL:  cmd.dp_op = DP_WMUL;
            ST_BIG:   cmd.dp_op = DP_BIGMUL;
            ST_ROUND: cmd.dp_op = DP_ROUND;
            ST_OUT:   cmd.out_load = slot_free;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        h_next = h_reg;
        k_next = k_reg;
        out_valid_next = out_valid_reg && sample_stall;
        if (cmd.tick_accept)
        begin
            h_next = '0;
        end
        if (state_reg == ST_WMUL)
        begin
            h_next = h_reg + 3'd1;
        end
        if (state_reg == ST_SQ)
        begin
            k_next = 2'd0;
        end
        if (state_reg == ST_HORN)
        begin
            k_next = k_reg + 2'd1;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            h_reg <= '0;
            k_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            h_reg <= h_next;
            k_reg <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A new beat is loaded only into a free output slot.
    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !sample_stall))
        else $error("output beat overwritten while stalled");

    // The harmonic counter never runs past the articulation's harmonic count.
    a_harm_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HARM) |-> ({1'b0, h_reg} < {1'b0, status.harmonics}))
        else $error("harmonic index beyond articulation");

    // A stalled result keeps the controller waiting with the beat still offered.
    a_wait_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_valid_reg && sample_stall)
        |=> (state_reg == ST_OUT && out_valid_reg))
        else $error("result dropped while output stalled");

    // The Horner loop always runs four steps before the final product.
    a_horner_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_YMUL) |-> ($past(state_reg) == ST_HORN && $past(k_reg) == 2'd3))
        else $error("Horner sequence cut short");

endmodule

[hdl/harmonic_bass_tone_oscillator_unit.sv]
// Top level of the harmonic bass tone oscillator: controller plus datapath.
// One additive-synthesis bass voice. A note-on beat loads the note's phase
// increment and starts the voice, a note-off beat stops it, and each tick beat
// returns one signed Q1.15 sample built from one to five sine harmonics chosen
// by the articulation register. Everything runs through one shared 32x32
// multiplier, and each harmonic takes nine steps (phase and fold, square,
// four Horner steps, final product, rounding, weighting). An active tick holds
// the input through an envelope step, its 3, 2, 5 or 1 harmonics (picked,
// fingerstyle, slap, muted), the big product, rounding and the output step,
// which waits while sample_stall holds the output. A note-on adds the increment
// step. The finished sample sits in an output register, so the next item is
// taken while it waits. Configuration writes are always ready and must be
// made while the voice has no item in flight.
module harmonic_bass_tone_oscillator_unit #(
    parameter int PHASE_BITS = hbto_pkg::PHASE_BITS_DEFAULT,
    parameter int SINE_TABLE_ENTRIES = hbto_pkg::SINE_ENTRIES_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    item_valid,
    output logic                                    item_stall,
    input  logic [1:0]                              op,
    input  logic [hbto_pkg::NOTE_BITS-1:0]          note,
    input  logic [hbto_pkg::GAIN_BITS-1:0]          velocity_gain,
    input  logic [hbto_pkg::GAIN_BITS-1:0]          envelope_gain,
    output logic                                    sample_valid,
    input  logic                                    sample_stall,
    output logic signed [hbto_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [hbto_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [hbto_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
    import hbto_pkg::*;

    hbto_cmd_t    cmd;
    hbto_status_t status;

    hbto_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    hbto_datapath #(
        .PHASE_BITS         (PHASE_BITS),
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .note          (note),
        .velocity_gain (velocity_gain),
        .envelope_gain (envelope_gain),
        .sample        (sample)
    );

endmodule
